// File: sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg - shared types and constants for the PCM feedback echo
// Sample types, register map codes and saturation limits.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 13;
  localparam int FB_W     = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // feedback is in 1/256 units
  localparam int FB_SHIFT = 8;

  typedef logic signed [SAMPLE_W-1:0] pfe_sample_t;

  localparam pfe_sample_t SAT_MAX = 16'sh7FFF;
  localparam pfe_sample_t SAT_MIN = 16'sh8000;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_ECHO_DELAY    = 1'b0,
    REG_ECHO_FEEDBACK = 1'b1
  } pfe_reg_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } pfe_q_stat_t;

  // per-sample control decided by the front end
  typedef struct packed {
    logic        echo_en;
    pfe_sample_t sample;
  } pfe_desc_t;

endpackage

// File: sv/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if - input sample channel
// Valid/ready channel carrying one PCM sample and its block start flag.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  import pfe_pkg::*;

  logic        valid;
  logic        ready;
  pfe_sample_t sample_in;
  logic        block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

// File: sv/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if - output sample channel
// Valid/ready channel carrying one echoed PCM sample.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  import pfe_pkg::*;

  logic        valid;
  logic        ready;
  pfe_sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: sv/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front - sample intake and classification
// Tracks ring write position and block progress, decides per sample whether
// the echo applies and where the ring is read, and pushes a queue entry.
// ----------------------------------------------------------------------------
module pfe_front #(
  parameter int MAX_DELAY = 8192,
  parameter int AW        = 13,
  parameter int QW        = 43
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pfe_in_if.sink                        in_chan,
  input  logic [pfe_pkg::DELAY_W-1:0]   echo_delay,
  input  pfe_pkg::pfe_q_stat_t          q_stat,
  output logic                          push,
  output logic [QW-1:0]                 push_data
);
  import pfe_pkg::*;

  localparam int CW = $clog2(MAX_DELAY + 1);

  logic [AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [CW-1:0] blk_cnt_r, blk_cnt_nxt;
  logic [CW-1:0] blk_cnt_eff;
  logic [AW-1:0] rd_idx;
  logic          echo_en;
  pfe_desc_t     desc;

  // take a beat whenever the queue has room
  assign in_chan.ready = !q_stat.full;
  assign push          = in_chan.valid && !q_stat.full;

  // classify the sample
  always_comb begin
    blk_cnt_eff = in_chan.block_start ? '0 : blk_cnt_r;
    echo_en     = (echo_delay != '0) && (32'(echo_delay) < MAX_DELAY) &&
                  (32'(blk_cnt_eff) >= 32'(echo_delay));
    if (32'(wr_pos_r) >= 32'(echo_delay)) begin
      rd_idx = AW'(32'(wr_pos_r) - 32'(echo_delay));
    end else begin
      rd_idx = AW'(32'(wr_pos_r) + MAX_DELAY - 32'(echo_delay));
    end
    desc.echo_en = echo_en;
    desc.sample  = in_chan.sample_in;
    push_data    = {rd_idx, wr_pos_r, desc};
  end

  // advance position and block count per accepted beat
  always_comb begin
    wr_pos_nxt  = wr_pos_r;
    blk_cnt_nxt = blk_cnt_r;
    if (push) begin
      wr_pos_nxt  = (32'(wr_pos_r) == MAX_DELAY - 1) ? '0 : wr_pos_r + 1'b1;
      blk_cnt_nxt = (32'(blk_cnt_eff) == MAX_DELAY) ? blk_cnt_eff
                                                    : blk_cnt_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r  <= '0;
      blk_cnt_r <= '0;
    end else begin
      wr_pos_r  <= wr_pos_nxt;
      blk_cnt_r <= blk_cnt_nxt;
    end
  end

endmodule

// File: sv/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue - two-entry queue between front and back end
// Lets the intake and the echo datapath stall independently.
// ----------------------------------------------------------------------------
module pfe_queue #(
  parameter int QW = 43
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [QW-1:0]        push_data,
  input  logic                 pop,
  output logic [QW-1:0]        pop_data,
  output pfe_pkg::pfe_q_stat_t q_stat
);
  import pfe_pkg::*;

  logic [QW-1:0] slot_r [2];
  logic          head_r, head_nxt;
  logic          tail_r, tail_nxt;
  logic [1:0]    count_r, count_nxt;

  assign pop_data     = slot_r[head_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  // pointer and count update
  always_comb begin
    head_nxt  = pop  ? ~head_r : head_r;
    tail_nxt  = push ? ~tail_r : tail_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

endmodule

// File: sv/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back - echo datapath
// Reads the history ring and, when the echo applies, scales the past output,
// adds and saturates; writes the result to the ring and the output register.
// ----------------------------------------------------------------------------
module pfe_back #(
  parameter int MAX_DELAY = 8192,
  parameter int AW        = 13,
  parameter int QW        = 43
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfe_pkg::pfe_q_stat_t       q_stat,
  input  logic [QW-1:0]              pop_data,
  output logic                       pop,
  input  logic [pfe_pkg::FB_W-1:0]   echo_feedback,
  pfe_out_if.source                  out_chan
);
  import pfe_pkg::*;

  localparam int DW = $bits(pfe_desc_t);

  // history ring of past outputs
  pfe_sample_t ring_mem [MAX_DELAY];

  pfe_desc_t     q_desc;
  logic [AW-1:0] q_rd_idx, q_wr_idx;

  // execute stage
  logic          ex_valid_r;
  pfe_desc_t     ex_desc_r;
  logic [AW-1:0] ex_wr_idx_r;
  logic          ex_fwd_r;
  pfe_sample_t   ring_q_r;
  logic          ex_fire;

  // output register
  logic          out_valid_r, out_valid_nxt;
  pfe_sample_t   out_sample_r;

  pfe_sample_t              past;
  logic signed [24:0]       prod;
  logic signed [17:0]       sum;
  pfe_sample_t              result;

  assign {q_rd_idx, q_wr_idx} = pop_data[QW-1:DW];
  assign q_desc               = pop_data[DW-1:0];

  // fire into the output register when it is free; refill behind it
  assign ex_fire = ex_valid_r && (!out_valid_r || out_chan.ready);
  assign pop     = !q_stat.empty && (!ex_valid_r || ex_fire);

  // scale the past output, add and saturate
  always_comb begin
    past = ex_fwd_r ? out_sample_r : ring_q_r;
    prod = past * $signed({1'b0, echo_feedback});
    sum  = 18'(ex_desc_r.sample) + 18'($signed(prod[24:FB_SHIFT]));
    if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
      result = sum[15:0];
    end else begin
      result = sum[17] ? SAT_MIN : SAT_MAX;
    end
    if (!ex_desc_r.echo_en) begin
      result = ex_desc_r.sample;
    end
  end

  // control of the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (pop) begin
      ex_valid_r <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_r <= 1'b0;
    end
  end

  // load the execute stage; read the ring and catch a write in the same cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_desc_r   <= q_desc;
      ex_wr_idx_r <= q_wr_idx;
      ex_fwd_r    <= ex_fire && (q_rd_idx == ex_wr_idx_r);
      ring_q_r    <= ring_mem[q_rd_idx];
    end
  end

  // write each result back to the ring
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      ring_mem[ex_wr_idx_r] <= result;
    end
  end

  // output register; it also serves as the forward path for a delay of one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ex_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_sample_r <= result;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;

endmodule

// File: sv/pcm_feedback_echo.sv
// ----------------------------------------------------------------------------
// pcm_feedback_echo - recursive echo on a signed 16-bit PCM stream
// Top level: configuration registers, intake, queue and echo datapath.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock and returns one echoed sample
// per beat, in order, from its output register, when the output is not
// stalled. The sustained rate of one sample per cycle is set by the execute
// stage, where the multiply, add and saturate of one sample must finish in
// the cycle before the next sample can use it at a delay of one. Past
// outputs live in a MAX_DELAY x 16 ring memory with one write and one
// registered read per cycle; it is not cleared after reset and needs no
// clearing pass, since the echo only reads entries written earlier in the
// same block. Program echo_delay (address 0) and echo_feedback (address 4)
// only while no samples are in flight; a delay of 0, or one not below
// MAX_DELAY, passes samples through unchanged.
// ----------------------------------------------------------------------------
module pcm_feedback_echo #(
  parameter int MAX_DELAY = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pfe_in_if.sink                       in_chan,
  pfe_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfe_pkg::CFG_AW-1:0]   paddr,
  input  logic [pfe_pkg::CFG_DW-1:0]   pwdata,
  output logic [pfe_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import pfe_pkg::*;

  localparam int AW = (MAX_DELAY > 2) ? $clog2(MAX_DELAY) : 1;
  localparam int QW = 2 * AW + $bits(pfe_desc_t);

  logic [DELAY_W-1:0] echo_delay_r;
  logic [FB_W-1:0]    echo_feedback_r;
  pfe_reg_t           reg_sel;
  logic               cfg_wr;

  pfe_q_stat_t        q_stat;
  logic               push, pop;
  logic [QW-1:0]      push_data, pop_data;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = pfe_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_delay_r    <= '0;
      echo_feedback_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ECHO_DELAY:    echo_delay_r    <= pwdata[DELAY_W-1:0];
        REG_ECHO_FEEDBACK: echo_feedback_r <= pwdata[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ECHO_DELAY:    prdata = CFG_DW'(echo_delay_r);
      REG_ECHO_FEEDBACK: prdata = CFG_DW'(echo_feedback_r);
      default:           prdata = '0;
    endcase
  end

  pfe_front #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW),
    .QW        (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .echo_delay (echo_delay_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  pfe_queue #(
    .QW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  pfe_back #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW),
    .QW        (QW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_data      (pop_data),
    .pop           (pop),
    .echo_feedback (echo_feedback_r),
    .out_chan      (out_chan)
  );

endmodule

// File: sv/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker - port-level checks for the PCM feedback echo
// Watches the sample channels and configuration port over time.
// ----------------------------------------------------------------------------
module pfe_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pfe_pkg::SAMPLE_W-1:0] sample_out,
  input logic                         pready
);
  import pfe_pkg::*;

  // beats accepted but not yet delivered
  logic [3:0] pending_r, pending_nxt;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r + 4'(in_beat) - 4'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // no result without an accepted sample behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 4'd0))
    else $error("output beat with no sample outstanding");

  // output channel is empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("stalled output beat changed");

  // configuration port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind pcm_feedback_echo pfe_checker u_pfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .sample_out (out_chan.sample_out),
  .pready     (pready)
);

// File: dv/echo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_checker - output checker for the PCM feedback echo
// Watches the configuration port and both sample channels, keeps its own
// copy of the echo state, predicts every output beat and compares it with
// what the block returns, oldest first.
// ----------------------------------------------------------------------------
module echo_checker #(
  parameter int MAX_DELAY = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pfe_in_if                          in_chan,
  pfe_out_if                         out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfe_pkg::CFG_AW-1:0] paddr,
  input  logic [pfe_pkg::CFG_DW-1:0] pwdata,
  input  logic                       pready,
  output int                         mismatch_count,
  output int                         samples_pending
);
  import pfe_pkg::*;

  // past outputs, indexed by ring slot
  pfe_sample_t       past_out [MAX_DELAY];
  int                ring_wr;
  int                block_len;
  logic [DELAY_W-1:0] delay_cfg;
  logic [FB_W-1:0]    gain_cfg;
  pfe_sample_t       echoed_q [$];

  // Compute the echoed sample for one input beat and advance the ring.
  function automatic pfe_sample_t echo_sample(pfe_sample_t x, logic starts_block);
    int          past_idx;
    int          scaled;
    int          total;
    pfe_sample_t y;
    if (starts_block) block_len = 0;
    y = x;
    if (delay_cfg != 0 && int'(delay_cfg) < MAX_DELAY && block_len >= int'(delay_cfg)) begin
      past_idx = (ring_wr + MAX_DELAY - int'(delay_cfg)) % MAX_DELAY;
      // floor division by 256 through an arithmetic shift
      scaled = (int'(past_out[past_idx]) * int'(gain_cfg)) >>> FB_SHIFT;
      total  = int'(x) + scaled;
      if (total > int'(SAT_MAX)) total = int'(SAT_MAX);
      if (total < int'(SAT_MIN)) total = int'(SAT_MIN);
      y = total[SAMPLE_W-1:0];
    end
    past_out[ring_wr] = y;
    ring_wr = (ring_wr + 1) % MAX_DELAY;
    if (block_len < MAX_DELAY) block_len++;
    return y;
  endfunction

  always @(posedge clk) begin
    pfe_sample_t want;
    if (!rst_n) begin
      ring_wr        = 0;
      block_len      = 0;
      delay_cfg      = '0;
      gain_cfg       = '0;
      mismatch_count = 0;
      echoed_q.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (pfe_reg_t'(paddr[2]))
          REG_ECHO_DELAY:    delay_cfg = pwdata[DELAY_W-1:0];
          REG_ECHO_FEEDBACK: gain_cfg  = pwdata[FB_W-1:0];
          default: ;
        endcase
      end
      // compare the output beat before taking the new input beat
      if (out_chan.valid && out_chan.ready) begin
        if (echoed_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected sample_out beat, expected none, got %0d",
                   $time, out_chan.sample_out);
        end else begin
          want = echoed_q.pop_front();
          if (out_chan.sample_out !== want) begin
            mismatch_count++;
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, out_chan.sample_out);
          end
        end
      end
      if (in_chan.valid && in_chan.ready)
        echoed_q.push_back(echo_sample(in_chan.sample_in, in_chan.block_start));
    end
    samples_pending = echoed_q.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top level for the PCM feedback echo
// Resets the block, programs delay and feedback through the register port,
// drives directed and random sample blocks with random idle cycles on both
// channels and judges the checker's mismatch count and pending samples.
// ----------------------------------------------------------------------------
module testbench;
  import pfe_pkg::*;

  localparam int ECHO_DEPTH   = 8192;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_DLY_CODE = 8191;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              idle_on;
  int                mismatch_count;
  int                samples_pending;
  int                random_sent;

  pfe_in_if  in_chan ();
  pfe_out_if out_chan ();

  pcm_feedback_echo #(.MAX_DELAY(ECHO_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  echo_checker #(.MAX_DELAY(ECHO_DEPTH)) echo_mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .samples_pending (samples_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // stall the output on about 31 percent of cycles while idling is on
  always @(posedge clk) begin
    out_chan.ready <= !idle_on || ($urandom_range(0, 99) >= 31);
  end

  // Hold valid low and wait until every predicted sample has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (samples_pending != 0);
  endtask

  // One register write: setup cycle, then access until pready.
  task automatic cfg_write(pfe_reg_t reg_idx, logic [CFG_DW-1:0] value);
    logic done;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain, then program both registers; upper data bits carry noise.
  task automatic set_echo(int unsigned dly, int unsigned gain);
    logic [CFG_DW-1:0] word;
    wait_drained();
    word = $urandom;
    word[DELAY_W-1:0] = dly[DELAY_W-1:0];
    cfg_write(REG_ECHO_DELAY, word);
    word = $urandom;
    word[FB_W-1:0] = gain[FB_W-1:0];
    cfg_write(REG_ECHO_FEEDBACK, word);
  endtask

  // Present one sample beat, with random idle cycles first.
  task automatic send_beat(pfe_sample_t x, logic bs);
    logic fire;
    while (idle_on && $urandom_range(0, 99) < 31) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.sample_in   <= x;
    in_chan.block_start <= bs;
    do begin
      @(negedge clk);
      fire = in_chan.ready;
      @(posedge clk);
    end while (!fire);
  endtask

  // Mostly full-range values, with extremes and values near zero.
  function automatic pfe_sample_t pick_sample();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 9))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return pfe_sample_t'(word[7:0]) - 16'sd128;
      default: return word[SAMPLE_W-1:0];
    endcase
  endfunction

  // Run blocks at one setting; most blocks outlast the delay.
  task automatic run_phase(int dly, int gain, int items);
    int   sent;
    int   len;
    logic open;
    logic bs;
    set_echo(dly, gain);
    sent = 0;
    // sometimes carry the previous block across the setting change
    open = ($urandom_range(0, 3) != 0);
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, dly + 1);
      else len = dly + $urandom_range(1, 80);
      for (int i = 0; i < len; i++) begin
        bs = ((i == 0) && open) || ($urandom_range(0, 99) == 0);
        send_beat(pick_sample(), bs);
        sent++;
        if ($urandom_range(0, 299) == 0) wait_drained();
      end
      open = 1'b1;
    end
    random_sent += sent;
  endtask

  initial begin
    int dly;
    int gain;
    int len;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.sample_in   = '0;
    in_chan.block_start = 1'b0;
    out_chan.ready      = 1'b0;
    idle_on             = 1'b1;
    random_sent         = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // no block start after reset: the stream counts as one open block
    set_echo(2, 128);
    send_beat(16'sd1000, 1'b0);
    send_beat(-16'sd1000, 1'b0);
    send_beat(16'sd500, 1'b0);
    send_beat(SAT_MAX, 1'b0);
    send_beat(SAT_MIN, 1'b0);
    send_beat(-16'sd1, 1'b0);

    // zero delay passes through
    set_echo(0, 255);
    send_beat(SAT_MAX, 1'b1);
    send_beat(SAT_MIN, 1'b0);
    send_beat(16'sd0, 1'b1);

    // delay of one at full gain: saturate at both ends
    set_echo(1, 255);
    send_beat(SAT_MAX, 1'b1);
    send_beat(SAT_MAX, 1'b0);
    send_beat(SAT_MAX, 1'b0);
    send_beat(SAT_MIN, 1'b1);
    send_beat(SAT_MIN, 1'b0);

    // floor of a small negative product
    set_echo(1, 1);
    send_beat(-16'sd1, 1'b1);
    send_beat(16'sd0, 1'b0);

    // block shorter than the delay passes through
    set_echo(3, 200);
    send_beat(16'sd100, 1'b1);
    send_beat(16'sd200, 1'b0);
    send_beat(16'sd300, 1'b1);
    send_beat(16'sd400, 1'b0);
    send_beat(16'sd500, 1'b0);
    send_beat(16'sd600, 1'b0);

    // a stretch without any idling on either side
    wait_drained();
    idle_on <= 1'b0;
    run_phase(1, 255, 300);
    wait_drained();
    idle_on <= 1'b1;

    // random settings and blocks
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       dly = 0;
        1:       dly = 1;
        2:       dly = 2;
        3:       dly = $urandom_range(3, 16);
        4:       dly = $urandom_range(17, 64);
        default: dly = $urandom_range(65, 400);
      endcase
      case ($urandom_range(0, 3))
        0:       gain = 0;
        1:       gain = 255;
        default: gain = $urandom_range(1, 254);
      endcase
      run_phase(dly, gain, $urandom_range(100, 250));
    end

    // longest delay: a block shorter than the delay passes through
    set_echo(MAX_DLY_CODE, $urandom_range(128, 255));
    len = $urandom_range(80, 120);
    for (int i = 0; i < len; i++) send_beat(pick_sample(), i == 0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pfe_pkg.sv
sv/pfe_in_if.sv
sv/pfe_out_if.sv
sv/pfe_front.sv
sv/pfe_queue.sv
sv/pfe_back.sv
sv/pcm_feedback_echo.sv
sv/pfe_checker.sv
dv/echo_checker.sv
dv/testbench.sv
